FILE: sv/bitmap_first_fit_allocator_unit_assert.svh
// Assertion macros for the bitmap first-fit allocator.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define BFFA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("allocator check failed");

// Check that a condition implies another in the following cycle.
`define BFFA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("allocator check failed");

`endif

FILE: sv/bffa_pkg.sv
// Shared constants, types and codes of the bitmap first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package bffa_pkg;

  localparam int MAP_ENTRIES    = 1024;
  localparam int SCAN_WORD_BITS = 32;
  localparam int MAP_WORDS      = (MAP_ENTRIES + SCAN_WORD_BITS - 1) / SCAN_WORD_BITS;
  localparam int WORD_IDX_W     = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W      = $clog2(SCAN_WORD_BITS);
  localparam int POS_W          = WORD_IDX_W + BIT_IDX_W;
  localparam int WCNT_W         = WORD_IDX_W + 1;
  localparam int NUM_W          = 11;
  localparam int STATUS_W       = 2;

  localparam logic [NUM_W-1:0] LIVE_MAX = NUM_W'(MAP_ENTRIES);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd3;

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic REG_ENTRIES_IN_USE = 1'b0;
  localparam logic REG_NUMBER_BASE    = 1'b1;

  typedef logic [SCAN_WORD_BITS-1:0] map_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_t;

  // Access to the bitmap store
  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    map_word_t             wr_data;
  } map_req_t;

endpackage
`default_nettype wire

FILE: sv/bitmap_first_fit_allocator_unit.sv
// Top level of the bitmap first-fit allocator: sequencer, word scan and result register.
// Allocate: one bitmap word read per cycle from word 0 up, until a free bit is found or the
//   last live word is checked; free: read, write, load; rejected requests go straight to load.
// One item at a time: the next item can be taken in the cycle after the result loads, and
//   the load waits while the output is stalled.
// Reset (rst, synchronous): bitmap all free, entries_in_use 1024, number_base 1, count 1024.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_first_fit_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [10:0] number, [15:11] zero
  input  wire logic        s_tuser,   // [0] mode
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [10:0] granted, [12:11] status, [23:13] free_left
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data
);
  import bffa_pkg::*;

  state_t                state, state_next;
  logic [NUM_W-1:0]      entries_in_use;
  logic                  number_base;
  logic [NUM_W-1:0]      free_total;
  logic [NUM_W-1:0]      live;
  logic [WCNT_W-1:0]     nwords;
  logic [WCNT_W-1:0]     rd_cnt;
  logic [WORD_IDX_W-1:0] chk_addr;
  logic                  chk_valid;
  logic [NUM_W-1:0]      free_idx;
  logic [NUM_W-1:0]      res_granted;
  logic [STATUS_W-1:0]   res_status;
  map_req_t              req;
  map_word_t             rd_data;
  map_word_t             word_mask;
  map_word_t             cand;
  map_word_t             lowest;
  map_word_t             free_bit;
  logic [BIT_IDX_W-1:0]  low_idx;
  logic [NUM_W-1:0]      rem;
  logic                  found;
  logic                  last_word;
  logic                  in_accept;
  logic                  out_free;
  logic [NUM_W-1:0]      in_number;
  logic [NUM_W-1:0]      in_idx;
  logic [STATUS_W-1:0]   in_status;
  logic                  in_bad;
  logic [NUM_W:0]        ft_inc;

  bffa_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // Live entry count and the number of words that cover it
  assign live   = (entries_in_use < LIVE_MAX) ? entries_in_use : LIVE_MAX;
  assign nwords = WCNT_W'((NUM_W+1)'(live) + (NUM_W+1)'(SCAN_WORD_BITS - 1) >> BIT_IDX_W);

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign in_number = s_tdata[NUM_W-1:0];
  assign in_idx    = in_number - NUM_W'(number_base);

  // Classify a request on entry
  always_comb begin
    in_bad    = 1'b1;
    in_status = STATUS_OK;
    if (s_tuser == MODE_ALLOC) begin
      in_bad    = (live == '0);
      in_status = (live == '0) ? STATUS_FULL : STATUS_OK;
    end else if (in_number == '0) begin
      in_status = STATUS_IGNORED;
    end else if (in_number < NUM_W'(number_base) || in_idx >= live) begin
      in_status = STATUS_RANGE;
    end else begin
      in_bad = 1'b0;
    end
  end

  // Mask off bits of the checked word at or above the live count
  assign rem = live - NUM_W'({chk_addr, {BIT_IDX_W{1'b0}}});
  always_comb begin
    for (int i = 0; i < SCAN_WORD_BITS; i++) begin
      word_mask[i] = (NUM_W'(i) < rem);
    end
  end

  // Find the lowest free bit of the checked word
  assign cand   = ~rd_data & word_mask;
  assign lowest = cand & (~cand + map_word_t'(1));
  assign found  = |cand;
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < SCAN_WORD_BITS; i++) begin
      if (lowest[i]) begin
        low_idx = low_idx | BIT_IDX_W'(i);
      end
    end
  end

  assign last_word = ({1'b0, chk_addr} == nwords - WCNT_W'(1));
  assign free_bit  = map_word_t'(1) << free_idx[BIT_IDX_W-1:0];
  assign ft_inc    = (NUM_W+1)'(free_total) + (NUM_W+1)'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_bad) begin
            state_next = ST_DONE;
          end else if (s_tuser == MODE_ALLOC) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FREE_RD;
          end
        end
      end
      ST_SCAN: begin
        if (chk_valid && (found || last_word)) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE_RD: state_next = ST_FREE_WR;
      ST_FREE_WR: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and bitmap access
  always_comb begin
    s_tready    = 1'b0;
    req.rd_en   = 1'b0;
    req.rd_addr = rd_cnt[WORD_IDX_W-1:0];
    req.wr_en   = 1'b0;
    req.wr_addr = chk_addr;
    req.wr_data = rd_data | lowest;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SCAN: begin
        req.rd_en = (rd_cnt < nwords);
        req.wr_en = chk_valid && found;
      end
      ST_FREE_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = free_idx[POS_W-1:BIT_IDX_W];
      end
      ST_FREE_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = free_idx[POS_W-1:BIT_IDX_W];
        req.wr_data = rd_data & ~free_bit;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Control state, registers and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= LIVE_MAX;
      number_base    <= 1'b1;
      free_total     <= LIVE_MAX;
      chk_valid      <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
          REG_NUMBER_BASE:    number_base    <= cfg_data[0];
          default: ;
        endcase
      end
      chk_valid <= (state == ST_SCAN) && req.rd_en;
      if (state == ST_SCAN && chk_valid && found && free_total != '0) begin
        free_total <= free_total - NUM_W'(1);
      end
      if (state == ST_FREE_WR) begin
        free_total <= (ft_inc < (NUM_W+1)'(live)) ? ft_inc[NUM_W-1:0] : live;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: scan pointers, request fields and result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      free_idx    <= in_idx;
      rd_cnt      <= '0;
      res_granted <= '0;
      res_status  <= in_status;
    end
    if (state == ST_SCAN) begin
      if (req.rd_en) begin
        rd_cnt <= rd_cnt + WCNT_W'(1);
      end
      chk_addr <= rd_cnt[WORD_IDX_W-1:0];
      if (chk_valid && found) begin
        res_granted <= NUM_W'({chk_addr, low_idx}) + NUM_W'(number_base);
      end else if (chk_valid && last_word) begin
        res_status <= STATUS_FULL;
      end
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {free_total, res_status, res_granted};
    end
  end

  `include "bitmap_first_fit_allocator_unit_assert.svh"

  `BFFA_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready)
  `BFFA_ASSERT_NOW(a_count_bounded, 1'b1, free_total <= LIVE_MAX)
  `BFFA_ASSERT_NOW(a_full_grants_zero, m_tvalid && m_tdata[12:11] == STATUS_FULL,
                   m_tdata[10:0] == '0)
  `BFFA_ASSERT_NOW(a_scan_in_range, state == ST_SCAN, rd_cnt <= nwords)

endmodule
`default_nettype wire

FILE: sv/bffa_map.sv
// Bitmap word store with per-word valid bits so unwritten words read as free.
`timescale 1ns / 1ps
`default_nettype none
module bffa_map (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bffa_pkg::map_req_t req,
  output bffa_pkg::map_word_t     rd_data
);
  import bffa_pkg::*;

  map_word_t            mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] word_valid;
  map_word_t            data_q;
  logic                 valid_q;

  // Write and registered read of the word array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_q <= mem[req.rd_addr];
    end
  end

  // Mark words written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        word_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= word_valid[req.rd_addr];
      end
    end
  end

  // Treat a word never written as all free
  assign rd_data = valid_q ? data_q : '0;

endmodule
`default_nettype wire
